### design/ibdz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibdz_pkg
// Shared types and constants for the biquad filter with output dead zone.
// ----------------------------------------------------------------------------
package ibdz_pkg;

	localparam int NUM_TAPS_DEF = 3;
	localparam int DEN_TAPS_DEF = 3;

	// products stay below 5 * 2^62 in magnitude, so 66 signed bits hold the sum
	localparam int ACC_W  = 66;
	localparam int DATA_W = 32;
	localparam int BAND_W = 31;
	localparam int ADDR_W = 5;

	// 1.0e-6 in q4.28, rounded down
	localparam logic [31:0] EPS_Q28 = 32'd268;

	localparam logic [31:0] NUM_COEF_0_RST = 32'h1000_0000;
	localparam logic [31:0] DEN_COEF_0_RST = 32'h1000_0000;

	localparam logic [2:0] REG_NUM_COEF_0 = 3'd0;
	localparam logic [2:0] REG_NUM_COEF_1 = 3'd1;
	localparam logic [2:0] REG_NUM_COEF_2 = 3'd2;
	localparam logic [2:0] REG_DEN_COEF_0 = 3'd3;
	localparam logic [2:0] REG_DEN_COEF_1 = 3'd4;
	localparam logic [2:0] REG_DEN_COEF_2 = 3'd5;
	localparam logic [2:0] REG_HOLD_BAND  = 3'd6;

	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [31:0] sample_in;
	} ibdz_in_t;

	typedef struct packed {
		logic signed [31:0] filtered_out;
		logic               saturated;
	} ibdz_out_t;

	typedef struct packed {
		logic clear;
		logic en;
		logic neg;
	} ibdz_mac_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DSTART,
		ST_DIV,
		ST_EMIT
	} ibdz_state_t;

endpackage

### design/ibdz_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibdz_mac
// Shared 32x32 multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module ibdz_mac #(
	parameter int ACC_W = ibdz_pkg::ACC_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ibdz_pkg::ibdz_mac_ctrl_t ctrl,
	input  logic signed [31:0]      opa,
	input  logic signed [31:0]      opb,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [63:0]      prod_s1;
	logic                    vld_s1;
	logic                    neg_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;

	assign prod_ext = {{(ACC_W-64){prod_s1[63]}}, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			neg_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctrl.en;
			neg_s1 <= ctrl.neg;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q <= neg_s1 ? (acc_q - prod_ext) : (acc_q + prod_ext);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
	end

	assign acc = acc_q;

endmodule

### design/ibdz_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibdz_div
// Bit-serial restoring divider: accumulator by a0, truncated and saturated.
// ----------------------------------------------------------------------------
module ibdz_div #(
	parameter int ACC_W = ibdz_pkg::ACC_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] dividend,
	input  logic signed [31:0]      divisor,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      quot,
	output logic                    sat
);

	localparam int MAG_W  = ACC_W - 1;
	localparam int STEP_W = $clog2(MAG_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [MAG_W-1:0]  mag_q;
	logic [32:0]       rem_q;
	logic [32:0]       q_q;
	logic              ovf_q;
	logic              neg_q;
	logic [31:0]       dmag_q;
	logic signed [31:0] quot_q;
	logic              sat_q;

	logic [ACC_W-1:0]  dvd_abs;
	logic [31:0]       dmag;
	logic              dvs_tiny;
	logic [32:0]       rem_sh;
	logic              ge;
	logic [32:0]       rem_n;
	logic [32:0]       q_n;
	logic              ovf_n;
	logic              sat_n;
	logic [31:0]       quot_n;

	always_comb begin
		dvd_abs  = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
		dmag     = divisor[31] ? (~divisor + 1'b1) : divisor;
		dvs_tiny = (dmag <= ibdz_pkg::EPS_Q28);
		rem_sh   = {rem_q[31:0], mag_q[MAG_W-1]};
		ge       = (rem_sh >= {1'b0, dmag_q});
		rem_n    = ge ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
		q_n      = {q_q[31:0], ge};
		ovf_n    = ovf_q | q_q[32];
		if (!neg_q) begin
			sat_n  = ovf_n | (q_n > 33'h0_7FFF_FFFF);
			quot_n = sat_n ? 32'h7FFF_FFFF : q_n[31:0];
		end else begin
			sat_n  = ovf_n | (q_n > 33'h0_8000_0000);
			quot_n = sat_n ? 32'h8000_0000 : (~q_n[31:0] + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !dvs_tiny;
				done_q <= dvs_tiny;
				cnt_q  <= STEP_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= dvd_abs[MAG_W-1:0];
			rem_q  <= '0;
			q_q    <= '0;
			ovf_q  <= 1'b0;
			neg_q  <= dividend[ACC_W-1] ^ divisor[31];
			dmag_q <= dmag;
			quot_q <= '0;
			sat_q  <= 1'b0;
		end else if (busy_q) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			rem_q <= rem_n;
			q_q   <= q_n;
			ovf_q <= ovf_n;
			if (cnt_q == STEP_W'(1)) begin
				quot_q <= quot_n;
				sat_q  <= sat_n;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign sat  = sat_q;

endmodule

### design/iir_biquad_with_dead_zone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_biquad_with_dead_zone
// Direct form I biquad in fixed point with an output dead zone.
// ----------------------------------------------------------------------------
// Samples (Q16.16) enter on the sample channel and one result per transaction
// leaves on the result channel, both with valid and stall. Coefficients
// (Q4.28) and the dead-zone band sit in an APB register bank at 4*index.
// A filter transaction runs one shared 32x32 multiplier over the
// NUM_TAPS + DEN_TAPS - 1 products, then a one-bit-per-cycle divider by a0
// over 65 dividend bits. When |a0| is below 1e-6 the divider raises done
// without dividing and the quotient is zero. A clear transaction skips the
// multiplier and divider and returns a zero result. One transaction is in
// flight at a time: sample_stall is high from acceptance until its result
// is loaded into the output register.
// A new sample is accepted while a finished result still waits; if the
// receiver keeps stalling, the next result waits in the sequencer.
// Reset clears both histories, the last emitted value and the registers
// to their defaults (b0 = a0 = 1.0, others 0).
// ----------------------------------------------------------------------------
module iir_biquad_with_dead_zone #(
	parameter int NUM_TAPS = ibdz_pkg::NUM_TAPS_DEF,
	parameter int DEN_TAPS = ibdz_pkg::DEN_TAPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  ibdz_pkg::ibdz_in_t           sample,
	output logic                         result_valid,
	input  logic                         result_stall,
	output ibdz_pkg::ibdz_out_t          result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ibdz_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int NT     = (NUM_TAPS < 1) ? 1 : ((NUM_TAPS > 3) ? 3 : NUM_TAPS);
	localparam int DT     = (DEN_TAPS < 1) ? 1 : ((DEN_TAPS > 3) ? 3 : DEN_TAPS);
	localparam int OH_D   = (DT > 1) ? (DT - 1) : 1;
	localparam int NTERMS = NT + DT - 1;
	localparam int IDX_W  = (NTERMS > 1) ? $clog2(NTERMS) : 1;
	localparam int ACC_W  = ibdz_pkg::ACC_W;

	ibdz_pkg::ibdz_state_t state_q, state_d;

	logic signed [31:0] num_coef_q [3];
	logic signed [31:0] den_coef_q [3];
	logic [ibdz_pkg::BAND_W-1:0] hold_band_q;

	logic signed [31:0] xh_q [NT];
	logic signed [31:0] yh_q [OH_D];
	logic signed [31:0] last_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               clr_q;
	logic               result_valid_q;
	ibdz_pkg::ibdz_out_t result_q;

	logic signed [31:0] ta [NTERMS];
	logic signed [31:0] tb [NTERMS];
	logic               tn [NTERMS];

	logic               sample_acc;
	logic               cfg_wr;
	logic               load;
	logic               div_start;
	ibdz_pkg::ibdz_mac_ctrl_t mac_ctrl;
	logic signed [31:0] opa;
	logic signed [31:0] opb;
	logic signed [ACC_W-1:0] acc;
	logic               div_busy;
	logic               div_done;
	logic signed [31:0] div_quot;
	logic               div_sat;

	logic signed [32:0] diff;
	logic [32:0]        adiff;
	logic               hold;
	ibdz_pkg::ibdz_out_t result_d;

	// product list: numerator taps, then the stored outputs
	for (genvar k = 0; k < NTERMS; k++) begin : g_term
		if (k < NT) begin : g_num
			assign ta[k] = xh_q[k];
			assign tb[k] = num_coef_q[k];
			assign tn[k] = 1'b0;
		end else begin : g_den
			assign ta[k] = yh_q[k-NT];
			assign tb[k] = den_coef_q[k-NT+1];
			assign tn[k] = 1'b1;
		end
	end

	assign sample_acc = sample_valid && !sample_stall;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign pready     = 1'b1;
	assign opa        = ta[cnt_q];
	assign opb        = tb[cnt_q];

	ibdz_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.opa   (opa),
		.opb   (opb),
		.acc   (acc)
	);

	ibdz_div #(
		.ACC_W(ACC_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc),
		.divisor (den_coef_q[0]),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (div_quot),
		.sat     (div_sat)
	);

	// dead zone
	always_comb begin
		diff  = {div_quot[31], div_quot} - {last_q[31], last_q};
		adiff = diff[32] ? (~diff + 1'b1) : diff;
		hold  = (adiff < {2'b00, hold_band_q});
		if (clr_q) begin
			result_d.filtered_out = '0;
			result_d.saturated    = 1'b0;
		end else begin
			result_d.filtered_out = hold ? last_q : div_quot;
			result_d.saturated    = div_sat;
		end
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		mac_ctrl     = '0;
		div_start    = 1'b0;
		load         = 1'b0;
		unique case (state_q)
			ibdz_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					if (sample.op == ibdz_pkg::OP_CLEAR) begin
						state_d = ibdz_pkg::ST_EMIT;
					end else begin
						mac_ctrl.clear = 1'b1;
						state_d        = ibdz_pkg::ST_MAC;
					end
				end
			end
			ibdz_pkg::ST_MAC: begin
				mac_ctrl.en  = 1'b1;
				mac_ctrl.neg = tn[cnt_q];
				if (cnt_q == IDX_W'(NTERMS - 1)) begin
					state_d = ibdz_pkg::ST_DRAIN;
				end
			end
			ibdz_pkg::ST_DRAIN: begin
				state_d = ibdz_pkg::ST_DSTART;
			end
			ibdz_pkg::ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ibdz_pkg::ST_DIV;
			end
			ibdz_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = ibdz_pkg::ST_EMIT;
				end
			end
			ibdz_pkg::ST_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					load    = 1'b1;
					state_d = ibdz_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ibdz_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibdz_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			clr_q          <= 1'b0;
			result_valid_q <= 1'b0;
			last_q         <= '0;
			for (int i = 0; i < NT; i++) begin
				xh_q[i] <= '0;
			end
			for (int i = 0; i < OH_D; i++) begin
				yh_q[i] <= '0;
			end
		end else begin
			if (sample_acc) begin
				cnt_q <= '0;
				clr_q <= (sample.op == ibdz_pkg::OP_CLEAR);
				if (sample.op == ibdz_pkg::OP_CLEAR) begin
					for (int i = 0; i < NT; i++) begin
						xh_q[i] <= '0;
					end
					for (int i = 0; i < OH_D; i++) begin
						yh_q[i] <= '0;
					end
				end else begin
					xh_q[0] <= sample.sample_in;
					for (int i = 1; i < NT; i++) begin
						xh_q[i] <= xh_q[i-1];
					end
				end
			end else if (state_q == ibdz_pkg::ST_MAC) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load && !clr_q) begin
				yh_q[0] <= div_quot;
				for (int i = 1; i < OH_D; i++) begin
					yh_q[i] <= yh_q[i-1];
				end
				if (!hold) begin
					last_q <= div_quot;
				end
			end
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// register bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_coef_q[0] <= ibdz_pkg::NUM_COEF_0_RST;
			num_coef_q[1] <= '0;
			num_coef_q[2] <= '0;
			den_coef_q[0] <= ibdz_pkg::DEN_COEF_0_RST;
			den_coef_q[1] <= '0;
			den_coef_q[2] <= '0;
			hold_band_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				ibdz_pkg::REG_NUM_COEF_0: num_coef_q[0] <= pwdata;
				ibdz_pkg::REG_NUM_COEF_1: num_coef_q[1] <= pwdata;
				ibdz_pkg::REG_NUM_COEF_2: num_coef_q[2] <= pwdata;
				ibdz_pkg::REG_DEN_COEF_0: den_coef_q[0] <= pwdata;
				ibdz_pkg::REG_DEN_COEF_1: den_coef_q[1] <= pwdata;
				ibdz_pkg::REG_DEN_COEF_2: den_coef_q[2] <= pwdata;
				ibdz_pkg::REG_HOLD_BAND:  hold_band_q   <= pwdata[ibdz_pkg::BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			ibdz_pkg::REG_NUM_COEF_0: prdata = num_coef_q[0];
			ibdz_pkg::REG_NUM_COEF_1: prdata = num_coef_q[1];
			ibdz_pkg::REG_NUM_COEF_2: prdata = num_coef_q[2];
			ibdz_pkg::REG_DEN_COEF_0: prdata = den_coef_q[0];
			ibdz_pkg::REG_DEN_COEF_1: prdata = den_coef_q[1];
			ibdz_pkg::REG_DEN_COEF_2: prdata = den_coef_q[2];
			ibdz_pkg::REG_HOLD_BAND:  prdata = {1'b0, hold_band_q};
			default:                  prdata = '0;
		endcase
	end

	// checks
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ibdz_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ibdz_pkg::ST_EMIT))
		else $error("result raised without a load");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ibdz_pkg::ST_IDLE |-> !div_busy)
		else $error("divider busy while idle");

	a_clear_hist: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_acc && sample.op == ibdz_pkg::OP_CLEAR) |=> (xh_q[0] == '0 && yh_q[0] == '0))
		else $error("histories not cleared");

endmodule
